// File: rtl/les_pkg.sv
// ----------------------------------------------------------------------------
// les_pkg
// Types and codes shared by the lenticular eye segmenter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package les_pkg;

    localparam int CNT_W   = 13;
    localparam int ANGLE_W = 16;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_EYE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_EYE = 2'd1;

    // eye codes
    localparam logic EYE_LEFT  = 1'b0;
    localparam logic EYE_RIGHT = 1'b1;

    typedef enum logic [1:0] {
        ITEM_EYE = 2'd0,
        ITEM_LEN = 2'd1,
        ITEM_END = 2'd2
    } t_item_type;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] exit_angle;
        logic                      angle_unknown;
        logic                      line_end;
    } t_pix;

    typedef struct packed {
        t_item_type       item_type;
        logic [CNT_W-1:0] item_value;
        logic             run_last;
    } t_res;

    // saturating clamp of a grown count sum
    function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W:0] s,
                                                 input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] r;
        r = (s > {1'b0, cap}) ? cap : s[CNT_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/les_if.sv
// ----------------------------------------------------------------------------
// les_if
// Channel interfaces: pixel input, segment output and configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface les_pix_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] exit_angle;
    logic        angle_unknown;
    logic        line_end;

    modport source (output valid, exit_angle, angle_unknown, line_end, input ready);
    modport sink   (input valid, exit_angle, angle_unknown, line_end, output ready);
endinterface

interface les_seg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_type;
    logic [12:0] item_value;
    logic        run_last;

    modport source (output valid, item_type, item_value, run_last, input ready);
    modport sink   (input valid, item_type, item_value, run_last, output ready);
endinterface

interface les_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/les_core.sv
// ----------------------------------------------------------------------------
// les_core
// Per-line segment state and the eye decision for one registered pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module les_core #(
    parameter int MAX_LINE_WIDTH = 4096
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_adv,
    input  wire les_pkg::t_pix     i_pix,
    input  wire signed [15:0]      i_left,
    input  wire signed [15:0]      i_right,
    output logic [1:0]             o_nres,
    output les_pkg::t_res          o_res0,
    output les_pkg::t_res          o_res1
);

    localparam int CAP_INT = (MAX_LINE_WIDTH < 8191) ? MAX_LINE_WIDTH : 8191;
    localparam logic [les_pkg::CNT_W-1:0] LEN_CAP = les_pkg::CNT_W'(CAP_INT);

    logic                        r_seen, n_seen;
    logic                        r_eye, n_eye;
    logic [les_pkg::CNT_W-1:0]   r_known, n_known;
    logic [les_pkg::CNT_W-1:0]   r_unk, n_unk;

    logic signed [16:0]          w_dl, w_dr;
    logic [16:0]                 w_abs_l, w_abs_r;
    logic                        w_eye;
    logic [les_pkg::CNT_W-1:0]   w_half;

    assign w_dl    = {i_pix.exit_angle[15], i_pix.exit_angle} - {i_left[15], i_left};
    assign w_dr    = {i_pix.exit_angle[15], i_pix.exit_angle} - {i_right[15], i_right};
    assign w_abs_l = w_dl[16] ? 17'(-w_dl) : 17'(w_dl);
    assign w_abs_r = w_dr[16] ? 17'(-w_dr) : 17'(w_dr);
    // tie goes right
    assign w_eye   = (w_abs_l < w_abs_r) ? les_pkg::EYE_LEFT : les_pkg::EYE_RIGHT;
    assign w_half  = {1'b0, r_unk[les_pkg::CNT_W-1:1]};

    always_comb begin
        n_seen  = r_seen;
        n_eye   = r_eye;
        n_known = r_known;
        n_unk   = r_unk;
        o_nres  = 2'd0;
        o_res0  = '{item_type: les_pkg::ITEM_EYE, item_value: '0, run_last: 1'b0};
        o_res1  = '{item_type: les_pkg::ITEM_END, item_value: '0, run_last: 1'b1};

        if (i_pix.angle_unknown) begin
            // leading unknowns count into the first segment
            if (!r_seen) begin
                n_known = les_pkg::sat_cnt({1'b0, r_known} + 14'd1, LEN_CAP);
            end else begin
                n_unk = les_pkg::sat_cnt({1'b0, r_unk} + 14'd1, LEN_CAP);
            end
        end else if (!r_seen) begin
            n_seen  = 1'b1;
            n_eye   = w_eye;
            n_known = les_pkg::sat_cnt({1'b0, r_known} + 14'd1, LEN_CAP);
            o_res0  = '{item_type: les_pkg::ITEM_EYE,
                        item_value: les_pkg::CNT_W'(w_eye),
                        run_last: !i_pix.line_end};
            o_nres  = 2'd1;
        end else if (w_eye != r_eye) begin
            // split the unknown run; the flipping pixel opens the new segment
            o_res0  = '{item_type: les_pkg::ITEM_LEN,
                        item_value: les_pkg::sat_cnt({1'b0, r_known} + {1'b0, w_half},
                                                     LEN_CAP),
                        run_last: !i_pix.line_end};
            o_nres  = 2'd1;
            n_known = les_pkg::sat_cnt({1'b0, w_half} + 14'(r_unk[0]) + 14'd1, LEN_CAP);
            n_unk   = '0;
            n_eye   = w_eye;
        end else begin
            n_known = les_pkg::sat_cnt({1'b0, r_known} + 14'd1, LEN_CAP);
        end

        if (i_pix.line_end) begin
            if (o_nres == 2'd1) begin
                o_nres = 2'd2;
            end else begin
                o_res0 = '{item_type: les_pkg::ITEM_END, item_value: '0, run_last: 1'b1};
                o_nres = 2'd1;
            end
            n_seen  = 1'b0;
            n_eye   = les_pkg::EYE_LEFT;
            n_known = '0;
            n_unk   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_eye   <= les_pkg::EYE_LEFT;
            r_known <= '0;
            r_unk   <= '0;
        end else if (i_adv) begin
            r_seen  <= n_seen;
            r_eye   <= n_eye;
            r_known <= n_known;
            r_unk   <= n_unk;
        end
    end

endmodule

`default_nettype wire

// File: rtl/les_oq.sv
// ----------------------------------------------------------------------------
// les_oq
// Two-entry result queue: takes up to two results, hands out one per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module les_oq (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire  [1:0]           i_push_n,
    input  wire les_pkg::t_res   i_res0,
    input  wire les_pkg::t_res   i_res1,
    input  wire                  i_pop,
    output les_pkg::t_res        o_head,
    output logic [1:0]           o_count
);

    les_pkg::t_res r_ent [2];
    les_pkg::t_res n_ent [2];
    logic [1:0]    r_cnt, n_cnt;
    logic [1:0]    w_base;

    always_comb begin
        n_ent[0] = i_pop ? r_ent[1] : r_ent[0];
        n_ent[1] = r_ent[1];
        w_base   = r_cnt - 2'(i_pop);
        // caller pushes two only into an empty queue
        if (i_push_n != 2'd0) begin
            n_ent[w_base[0]] = i_res0;
        end
        if (i_push_n == 2'd2) begin
            n_ent[1] = i_res1;
        end
        n_cnt = w_base + i_push_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_ent[0] <= n_ent[0];
        r_ent[1] <= n_ent[1];
    end

    assign o_head  = r_ent[0];
    assign o_count = r_cnt;

endmodule

`default_nettype wire

// File: rtl/lenticular_eye_segmenter.sv
// Path: a pixel beat is registered in the input stage, its results in the result queue.
// Throughput: one pixel per cycle while the queue has room. Queue room is judged
// before the cycle's output beat leaves, so a pixel with two results waits for an
// empty queue and the next pixel with a result waits while both are queued, even
// with the output always ready.
// Reset (synchronous, active low) clears eye angles, line state and queue.
// ----------------------------------------------------------------------------
// lenticular_eye_segmenter
// Assigns pixels of a display line to the nearer eye and emits segments.
// ----------------------------------------------------------------------------
`default_nettype none

module lenticular_eye_segmenter #(
    parameter int MAX_LINE_WIDTH = 4096
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    les_pix_if.sink      i_pix,
    les_cfg_if.sink      i_cfg,
    les_seg_if.source    o_seg
);

    logic signed [15:0] r_left, r_right;
    logic               r_in_vld;
    les_pkg::t_pix      r_in;

    logic [1:0]         w_nres;
    les_pkg::t_res      w_res0, w_res1, w_head;
    logic [1:0]         w_count;
    logic               w_adv;
    logic [1:0]         w_push_n;
    logic               w_pop;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_right <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                les_pkg::CFG_LEFT_EYE:  r_left  <= i_cfg.data;
                les_pkg::CFG_RIGHT_EYE: r_right <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // input stage moves on when the queue has room for all its results
    assign w_adv       = r_in_vld && (w_nres <= (2'd2 - w_count));
    assign w_push_n    = w_adv ? w_nres : 2'd0;
    assign i_pix.ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_pix.valid && i_pix.ready) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
        if (i_pix.valid && i_pix.ready) begin
            r_in <= '{exit_angle: i_pix.exit_angle,
                      angle_unknown: i_pix.angle_unknown,
                      line_end: i_pix.line_end};
        end
    end

    les_core #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_pix   (r_in),
        .i_left  (r_left),
        .i_right (r_right),
        .o_nres  (w_nres),
        .o_res0  (w_res0),
        .o_res1  (w_res1)
    );

    les_oq u_oq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_res0   (w_res0),
        .i_res1   (w_res1),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_count  (w_count)
    );

    assign w_pop            = o_seg.valid && o_seg.ready;
    assign o_seg.valid      = (w_count != 2'd0);
    assign o_seg.item_type  = w_head.item_type;
    assign o_seg.item_value = w_head.item_value;
    assign o_seg.run_last   = w_head.run_last;

    a_two_into_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_n == 2'd2) |-> (w_count == 2'd0))
        else $error("two results pushed into a non-empty queue");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_adv) |=> (r_in_vld && $stable(r_in)))
        else $error("stalled pixel lost or changed");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (w_count == ($past(w_count) + $past(w_push_n) - 2'($past(w_pop)))))
        else $error("queue count out of step with push and pop");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (w_count != 2'd3))
        else $error("result queue overflow");

endmodule

`default_nettype wire

// File: bench/les_seg_checker.sv
// ----------------------------------------------------------------------------
// les_seg_checker
// Watches the pixel, config and segment channels of the eye segmenter. It
// keeps its own line state, queues the segment beats each pixel should
// produce and compares every output beat with the oldest one queued.
// ----------------------------------------------------------------------------
`default_nettype none

module les_seg_checker #(
    parameter int MAX_LINE_WIDTH = 4096
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    les_pix_if   pix,
    les_cfg_if   cfg,
    les_seg_if   seg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_beats_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import les_pkg::*;

    localparam int LEN_CAP = (MAX_LINE_WIDTH < 8191) ? MAX_LINE_WIDTH : 8191;

    logic signed [ANGLE_W-1:0] left_angle;
    logic signed [ANGLE_W-1:0] right_angle;
    logic                      line_has_known;
    logic                      open_eye;
    logic [CNT_W-1:0]          open_len;
    logic [CNT_W-1:0]          gap_len;

    t_res seg_expect_q[$];
    int   fail_cnt = 0;
    int   beats_checked = 0;

    function automatic logic [CNT_W-1:0] capped_add(input int a, input int b);
        int s;
        s = a + b;
        return (s > LEN_CAP) ? CNT_W'(LEN_CAP) : CNT_W'(s);
    endfunction

    // tie goes to the right eye
    function automatic logic nearer_eye(input logic signed [ANGLE_W-1:0] angle);
        int dl;
        int dr;
        dl = int'(angle) - int'(left_angle);
        dr = int'(angle) - int'(right_angle);
        if (dl < 0) dl = -dl;
        if (dr < 0) dr = -dr;
        return (dl < dr) ? EYE_LEFT : EYE_RIGHT;
    endfunction

    task automatic clear_line();
        line_has_known = 1'b0;
        open_eye       = EYE_LEFT;
        open_len       = '0;
        gap_len        = '0;
    endtask

    task automatic predict_pixel(input logic signed [ANGLE_W-1:0] angle,
                                 input logic unk, input logic last);
        t_res             res [2];
        int               n;
        logic             eye;
        logic [CNT_W-1:0] half;
        n = 0;
        if (unk) begin
            // unknowns ahead of the first known pixel belong to the first segment
            if (!line_has_known)
                open_len = capped_add(open_len, 1);
            else
                gap_len = capped_add(gap_len, 1);
        end else begin
            eye = nearer_eye(angle);
            if (!line_has_known) begin
                line_has_known = 1'b1;
                open_eye       = eye;
                open_len       = capped_add(open_len, 1);
                res[n] = '{ITEM_EYE, CNT_W'(eye), 1'b0};
                n++;
            end else if (eye != open_eye) begin
                // unknown run is split; the odd pixel goes to the new segment
                half   = gap_len >> 1;
                res[n] = '{ITEM_LEN, capped_add(open_len, half), 1'b0};
                n++;
                open_len = capped_add(int'(half) + int'(gap_len[0]), 1);
                gap_len  = '0;
                open_eye = eye;
            end else begin
                open_len = capped_add(open_len, 1);
            end
        end
        if (last) begin
            res[n] = '{ITEM_END, '0, 1'b0};
            n++;
            clear_line();
        end
        if (n > 0)
            res[n-1].run_last = 1'b1;
        for (int k = 0; k < n; k++)
            seg_expect_q = {seg_expect_q, res[k]};
    endtask

    task automatic report_mismatch(input string field, input int exp_v, input int got_v);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            left_angle  = '0;
            right_angle = '0;
            clear_line();
            seg_expect_q.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_LEFT_EYE:  left_angle  = cfg.data;
                    CFG_RIGHT_EYE: right_angle = cfg.data;
                    default: ;
                endcase
            end
            if (pix.valid && pix.ready)
                predict_pixel(pix.exit_angle, pix.angle_unknown, pix.line_end);
            if (seg.valid && seg.ready) begin
                beats_checked++;
                if (seg_expect_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, got type %0d value %0d",
                             $time, seg.item_type, seg.item_value);
                    fail_cnt++;
                end else begin
                    want = seg_expect_q.pop_front();
                    if (seg.item_type !== want.item_type)
                        report_mismatch("item_type", want.item_type, seg.item_type);
                    if (seg.item_value !== want.item_value)
                        report_mismatch("item_value", want.item_value, seg.item_value);
                    if (seg.run_last !== want.run_last)
                        report_mismatch("run_last", want.run_last, seg.run_last);
                end
            end
        end
        o_fail_count    <= fail_cnt;
        o_pending       <= seg_expect_q.size();
        o_beats_checked <= beats_checked;
    end

endmodule

`default_nettype wire

// File: bench/lenticular_eye_segmenter_tb.sv
// ----------------------------------------------------------------------------
// lenticular_eye_segmenter_tb
// Drives display lines of pixels and eye-angle settings into the segmenter
// with random gaps on input and backpressure on output; a side checker
// predicts every segment beat. Directed lines hit angle extremes, ties,
// leading unknowns and eye flips on the last pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module lenticular_eye_segmenter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import les_pkg::*;

    localparam int MAX_LINE_WIDTH = 4096;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int TAIL_CYCLES    = 8;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_PIXELS   = 86;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    les_pix_if pix ();
    les_cfg_if cfg ();
    les_seg_if seg ();

    int fail_count;
    int pending;
    int beats_checked;

    int cycle_cnt    = 0;
    int pixels_sent  = 0;
    int lines_sent   = 0;
    int eye_settings = 0;
    int cur_left     = 0;
    int cur_right    = 0;
    logic quiet      = 1'b0;

    lenticular_eye_segmenter #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix),
        .i_cfg  (cfg),
        .o_seg  (seg)
    );

    les_seg_checker #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .pix            (pix),
        .cfg            (cfg),
        .seg            (seg),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_beats_checked(beats_checked)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected", cycle_cnt, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // mostly short gaps, a few long ones; none while quiet
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic signed [ANGLE_W-1:0] pick_angle(input logic side);
        int r;
        int base;
        r = $urandom_range(0, 99);
        if (r < 10)
            return ANGLE_W'($urandom);
        if (r < 25) begin
            // around the midpoint, where ties land
            base = ((cur_left + cur_right) >>> 1) + int'($urandom_range(0, 2)) - 1;
        end else begin
            base = (side == EYE_LEFT) ? cur_left : cur_right;
            base = base + int'($urandom_range(0, 64)) - 32;
        end
        if (base > 32767)  base = 32767;
        if (base < -32768) base = -32768;
        return ANGLE_W'(base);
    endfunction

    task automatic send_pixel(input logic signed [ANGLE_W-1:0] angle,
                              input logic unk, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid         <= 1'b1;
        pix.exit_angle    <= angle;
        pix.angle_unknown <= unk;
        pix.line_end      <= last;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        pixels_sent++;
        if (last)
            lines_sent++;
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
    endtask

    task automatic set_eyes(input int left, input int right);
        cfg_beat(CFG_LEFT_EYE, 16'(left));
        cfg_beat(CFG_RIGHT_EYE, 16'(right));
        cfg.valid <= 1'b0;
        cur_left  = left;
        cur_right = right;
        eye_settings++;
    endtask

    // drain: every queued beat out, then a tail wait for pixels with no result
    task automatic settle();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // runs of one eye with unknowns sprinkled in
    task automatic send_line(input int len, input int unk_pct);
        logic side;
        int   run;
        side = 1'($urandom);
        run  = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < unk_pct) begin
                send_pixel(ANGLE_W'($urandom), 1'b1, k == len - 1);
            end else begin
                send_pixel(pick_angle(side), 1'b0, k == len - 1);
                run--;
                if (run == 0) begin
                    side = ~side;
                    run  = $urandom_range(1, 8);
                end
            end
        end
    endtask

    initial begin : seg_drain
        int hold;
        int gap;
        seg.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            hold = $urandom_range(1, 16);
            gap  = pick_gap();
            seg.ready <= 1'b1;
            repeat (hold) @(posedge i_clk);
            if (gap > 0) begin
                seg.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int start;
        int len;
        int unk_pct;
        pix.valid         = 1'b0;
        pix.exit_angle    = '0;
        pix.angle_unknown = 1'b0;
        pix.line_end      = 1'b0;
        cfg.valid         = 1'b0;
        cfg.index         = CFG_LEFT_EYE;
        cfg.data          = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset angles are both zero: every pixel is a tie
        send_pixel(16'sd0, 1'b0, 1'b0);
        send_pixel(-16'sd32768, 1'b0, 1'b0);
        send_pixel(16'sd32767, 1'b0, 1'b1);
        settle();

        set_eyes(-32768, 32767);
        // line of one unknown pixel: end marker only
        send_pixel(ANGLE_W'($urandom), 1'b1, 1'b1);
        // leading unknowns, odd unknown run split, flip on the last pixel
        send_pixel(ANGLE_W'($urandom), 1'b1, 1'b0);
        send_pixel(ANGLE_W'($urandom), 1'b1, 1'b0);
        send_pixel(-16'sd32768, 1'b0, 1'b0);
        send_pixel(16'sd32767, 1'b0, 1'b0);
        send_pixel(ANGLE_W'($urandom), 1'b1, 1'b0);
        send_pixel(ANGLE_W'($urandom), 1'b1, 1'b0);
        send_pixel(ANGLE_W'($urandom), 1'b1, 1'b0);
        send_pixel(-16'sd32768, 1'b0, 1'b0);
        send_pixel(-16'sd1, 1'b0, 1'b0);
        send_pixel(16'sd0, 1'b0, 1'b0);
        send_pixel(-16'sd32768, 1'b0, 1'b1);
        // first known pixel is also the last one
        send_pixel(16'sd32767, 1'b0, 1'b1);
        // line ending on unknowns after a known pixel
        send_pixel(16'sd100, 1'b0, 1'b0);
        send_pixel(ANGLE_W'($urandom), 1'b1, 1'b0);
        send_pixel(ANGLE_W'($urandom), 1'b1, 1'b1);
        settle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            quiet = (ph == 3);
            case (ph)
                0: set_eyes(-32768, 32767);
                1: set_eyes(32767, -32768);
                2: set_eyes(250, 250);
                4: set_eyes(-1, 0);
                5: begin
                    // unused index must be ignored
                    cfg_beat(CFG_SPARE, 16'($urandom));
                    set_eyes(0, 0);
                end
                default: set_eyes(int'(16'sh8000 + 16'($urandom)) - 32768,
                                  int'(16'($urandom)) - 32768);
            endcase
            start = pixels_sent;
            while (pixels_sent - start < PHASE_PIXELS) begin
                len = $urandom_range(1, 24);
                if ($urandom_range(0, 9) == 0) begin
                    // noise: raw angles, coin-flip unknowns
                    for (int k = 0; k < len; k++)
                        send_pixel(ANGLE_W'($urandom), 1'($urandom), k == len - 1);
                end else begin
                    case ($urandom_range(0, 4))
                        0:       unk_pct = 0;
                        1:       unk_pct = 10;
                        2:       unk_pct = 30;
                        3:       unk_pct = 60;
                        default: unk_pct = 100;
                    endcase
                    send_line(len, unk_pct);
                end
            end
            settle();
        end
        quiet = 1'b0;

        $display("Sent %0d pixels in %0d lines under %0d eye-angle settings.",
                 pixels_sent, lines_sent, eye_settings);
        $display("Compared %0d segment beats, %0d mismatches.", beats_checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
